// ===== design/kcl_pkg.sv =====
// ----------------------------------------------------------------------------
// kcl_pkg: shared types and constants of the keyed code lock
// Holds the code length limit, mode and event codes, register indexes,
// key codes and the payload structures of the item and result channels.
// ----------------------------------------------------------------------------
`default_nettype none

package kcl_pkg;

  localparam int unsigned CODE_MAX = 8;
  localparam int unsigned CODE_IDX_W = (CODE_MAX > 1) ? $clog2(CODE_MAX) : 1;
  localparam int unsigned CODE_CNT_W = $clog2(CODE_MAX + 1);
  localparam int unsigned RESET_LEN = (CODE_MAX < 4) ? CODE_MAX : 4;

  localparam logic [1:0] MODE_NORMAL  = 2'd0;
  localparam logic [1:0] MODE_CHANGE  = 2'd1;
  localparam logic [1:0] MODE_CONFIRM = 2'd2;

  localparam logic [3:0] EV_NONE     = 4'd0;
  localparam logic [3:0] EV_MATCH    = 4'd1;
  localparam logic [3:0] EV_UNLOCKED = 4'd2;
  localparam logic [3:0] EV_MISMATCH = 4'd3;
  localparam logic [3:0] EV_LIMIT    = 4'd4;
  localparam logic [3:0] EV_TIMEOUT  = 4'd5;
  localparam logic [3:0] EV_CHANGE   = 4'd6;
  localparam logic [3:0] EV_ASK      = 4'd7;
  localparam logic [3:0] EV_REPLACED = 4'd8;
  localparam logic [3:0] EV_DROPPED  = 4'd9;

  localparam logic [1:0] REG_IDLE_TIMEOUT  = 2'd0;
  localparam logic [1:0] REG_FAILURE_LIMIT = 2'd1;

  localparam logic [15:0] IDLE_TIMEOUT_RESET  = 16'd1500;
  localparam logic [2:0]  FAILURE_LIMIT_RESET = 3'd3;
  localparam logic [15:0] IDLE_TICKS_MAX      = 16'hFFFF;

  localparam logic KIND_CHAR = 1'b0;
  localparam logic KIND_TICK = 1'b1;

  localparam logic [7:0] KEY_ENTER   = 8'h0D;
  localparam logic [7:0] KEY_PLUS    = 8'h2B;
  localparam logic [7:0] KEY_YES     = 8'h79;
  localparam logic [7:0] UPPER_FIRST = 8'h41;
  localparam logic [7:0] UPPER_LAST  = 8'h5A;
  localparam logic [7:0] LOWER_FIRST = 8'h61;
  localparam logic [7:0] LOWER_LAST  = 8'h7A;
  localparam logic [7:0] CASE_OFFSET = 8'd32;

  typedef struct packed {
    logic       kind;
    logic [7:0] char_code;
  } kcl_item_t;

  typedef struct packed {
    logic       echo_valid;
    logic [7:0] echo_char;
    logic [3:0] event_res;
    logic [1:0] lock_mode;
  } kcl_result_t;

  function automatic logic [7:0] reset_char(input int unsigned pos);
    logic [7:0] c;
    case (pos)
      0: c = 8'h70;
      1: c = 8'h61;
      2: c = 8'h73;
      3: c = 8'h73;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

// ===== design/kcl_item_if.sv =====
// ----------------------------------------------------------------------------
// kcl_item_if: input item channel
// Valid/ready channel carrying one character or tick per transaction.
// ----------------------------------------------------------------------------
`default_nettype none

interface kcl_item_if
  import kcl_pkg::*;
;
  logic      valid;
  logic      ready;
  kcl_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== design/kcl_result_if.sv =====
// ----------------------------------------------------------------------------
// kcl_result_if: result channel
// Valid/ready channel carrying one result per transaction.
// ----------------------------------------------------------------------------
`default_nettype none

interface kcl_result_if
  import kcl_pkg::*;
;
  logic        valid;
  logic        ready;
  kcl_result_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== design/kcl_cfg_if.sv =====
// ----------------------------------------------------------------------------
// kcl_cfg_if: configuration write channel
// Valid/ready channel carrying a register index and write data.
// ----------------------------------------------------------------------------
`default_nettype none

interface kcl_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [15:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== design/keyed_code_lock_top.sv =====
// ----------------------------------------------------------------------------
// keyed_code_lock_top: character driven code lock
// Filters characters, checks them against the stored code, handles code
// change and confirmation, and clears a partial entry after an idle timeout.
// ----------------------------------------------------------------------------
// The block takes one transaction per clock cycle while the result
// channel does not stall, and returns exactly one result for each. An item
// passes an input register and then the result register, and the whole
// state update for an item is computed from the input register and written
// at the same edge as its result.
// Back-pressure on the result channel stalls the input register, and the
// input channel stays ready as long as the input register is empty or can move on.
// Configuration writes are always taken; they are meant to occur while no
// item is in flight.
// ----------------------------------------------------------------------------
`default_nettype none

module keyed_code_lock_top
  import kcl_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  kcl_item_if.sink     item,
  kcl_result_if.source result,
  kcl_cfg_if.sink      cfg
);

  logic [15:0] idle_timeout;
  logic [2:0]  failure_limit;

  logic            s1_valid;
  kcl_item_t       s1_item;
  logic            s1_adv;
  logic            res_valid;
  kcl_result_t     res_data;
  kcl_result_t     res_next;

  logic [1:0]            mode;
  logic [7:0]            code_store [CODE_MAX];
  logic [CODE_CNT_W-1:0] code_len;
  logic [CODE_CNT_W-1:0] entry_pos;
  logic [2:0]            fail_count;
  logic [7:0]            pending_code [CODE_MAX];
  logic [CODE_CNT_W-1:0] pending_len;
  logic [15:0]           idle_ticks;

  logic [1:0]            mode_next;
  logic [CODE_CNT_W-1:0] code_len_next;
  logic [CODE_CNT_W-1:0] entry_pos_next;
  logic [2:0]            fail_count_next;
  logic [CODE_CNT_W-1:0] pending_len_next;
  logic [15:0]           idle_ticks_next;
  logic                  pend_wr;
  logic                  code_copy;

  logic [7:0]            ch;
  logic                  is_upper;
  logic                  is_lower;
  logic                  ok;
  logic [7:0]            folded;
  logic [15:0]           ticks_inc;
  logic                  hit;
  logic [CODE_CNT_W-1:0] entry_inc;
  logic [CODE_CNT_W-1:0] pending_inc;
  logic [2:0]            fail_inc;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      idle_timeout  <= IDLE_TIMEOUT_RESET;
      failure_limit <= FAILURE_LIMIT_RESET;
    end else if (cfg.valid) begin
      if (cfg.index == REG_IDLE_TIMEOUT) begin
        idle_timeout <= cfg.data;
      end else if (cfg.index == REG_FAILURE_LIMIT) begin
        failure_limit <= cfg.data[2:0];
      end
    end
  end

  assign s1_adv       = s1_valid && (!res_valid || result.ready);
  assign item.ready   = !s1_valid || s1_adv;
  assign result.valid = res_valid;
  assign result.data  = res_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (item.ready) begin
      s1_valid <= item.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item.ready && item.valid) begin
      s1_item <= item.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (s1_adv) begin
      res_valid <= 1'b1;
    end else if (result.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      res_data <= res_next;
    end
  end

  assign ch          = s1_item.char_code;
  assign is_upper    = (ch >= UPPER_FIRST) && (ch <= UPPER_LAST);
  assign is_lower    = (ch >= LOWER_FIRST) && (ch <= LOWER_LAST);
  assign folded      = is_upper ? (ch + CASE_OFFSET) : ch;
  assign ticks_inc   = (idle_ticks == IDLE_TICKS_MAX) ? idle_ticks : idle_ticks + 16'd1;
  assign entry_inc   = entry_pos + 1'b1;
  assign pending_inc = pending_len + 1'b1;
  assign fail_inc    = fail_count + 3'd1;
  assign hit = (entry_pos < CODE_CNT_W'(CODE_MAX)) && (entry_pos < code_len) &&
               (code_store[entry_pos[CODE_IDX_W-1:0]] == folded);

  always_comb begin
    ok = is_upper || is_lower ||
         ((ch == KEY_ENTER) && (mode == MODE_CHANGE)) ||
         ((ch == KEY_PLUS) && (mode == MODE_NORMAL));

    mode_next        = mode;
    code_len_next    = code_len;
    entry_pos_next   = entry_pos;
    fail_count_next  = fail_count;
    pending_len_next = pending_len;
    idle_ticks_next  = idle_ticks;
    pend_wr          = 1'b0;
    code_copy        = 1'b0;
    res_next.echo_valid = 1'b0;
    res_next.echo_char  = 8'h00;
    res_next.event_res  = EV_NONE;

    if (s1_item.kind == KIND_TICK) begin
      idle_ticks_next = ticks_inc;
      if ((mode == MODE_NORMAL) && (entry_pos != '0) && (ticks_inc >= idle_timeout)) begin
        entry_pos_next     = '0;
        fail_count_next    = 3'd0;
        idle_ticks_next    = 16'd0;
        res_next.event_res = EV_TIMEOUT;
      end
    end else if (!ok) begin
      res_next.event_res = EV_DROPPED;
    end else begin
      res_next.echo_valid = 1'b1;
      res_next.echo_char  = folded;
      idle_ticks_next     = 16'd0;
      unique case (mode)
        MODE_NORMAL: begin
          if (folded == KEY_PLUS) begin
            mode_next          = MODE_CHANGE;
            res_next.event_res = EV_CHANGE;
          end else if (hit) begin
            if (entry_inc >= code_len) begin
              entry_pos_next     = '0;
              fail_count_next    = 3'd0;
              res_next.event_res = EV_UNLOCKED;
            end else begin
              entry_pos_next     = entry_inc;
              res_next.event_res = EV_MATCH;
            end
          end else begin
            entry_pos_next = '0;
            if (fail_inc == failure_limit) begin
              fail_count_next    = 3'd0;
              res_next.event_res = EV_LIMIT;
            end else begin
              fail_count_next    = fail_inc;
              res_next.event_res = EV_MISMATCH;
            end
          end
        end
        MODE_CHANGE: begin
          if (folded == KEY_ENTER) begin
            if (pending_len == '0) begin
              mode_next      = MODE_NORMAL;
              entry_pos_next = '0;
            end else begin
              mode_next          = MODE_CONFIRM;
              res_next.event_res = EV_ASK;
            end
          end else begin
            if (pending_len < CODE_CNT_W'(CODE_MAX)) begin
              pend_wr          = 1'b1;
              pending_len_next = pending_inc;
            end
            if (pending_len_next >= CODE_CNT_W'(CODE_MAX)) begin
              mode_next          = MODE_CONFIRM;
              res_next.event_res = EV_ASK;
            end
          end
        end
        MODE_CONFIRM: begin
          if ((folded == KEY_YES) && (pending_len != '0)) begin
            code_copy          = 1'b1;
            code_len_next      = pending_len;
            res_next.event_res = EV_REPLACED;
          end
          pending_len_next = '0;
          mode_next        = MODE_NORMAL;
          entry_pos_next   = '0;
        end
        default: begin
          mode_next      = MODE_NORMAL;
          entry_pos_next = '0;
        end
      endcase
    end
    res_next.lock_mode = mode_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode        <= MODE_NORMAL;
      code_len    <= CODE_CNT_W'(RESET_LEN);
      entry_pos   <= '0;
      fail_count  <= 3'd0;
      pending_len <= '0;
      idle_ticks  <= 16'd0;
    end else if (s1_adv) begin
      mode        <= mode_next;
      code_len    <= code_len_next;
      entry_pos   <= entry_pos_next;
      fail_count  <= fail_count_next;
      pending_len <= pending_len_next;
      idle_ticks  <= idle_ticks_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < CODE_MAX; i++) begin
        code_store[i] <= reset_char(i);
      end
    end else if (s1_adv && code_copy) begin
      for (int i = 0; i < CODE_MAX; i++) begin
        code_store[i] <= pending_code[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && pend_wr) begin
      pending_code[pending_len[CODE_IDX_W-1:0]] <= folded;
    end
  end

  a_entry_below_len: assert property (@(posedge clk) disable iff (rst)
    entry_pos < code_len)
    else $error("Entry position has reached the code length.");

  a_code_len_range: assert property (@(posedge clk) disable iff (rst)
    (code_len != '0) && (code_len <= CODE_CNT_W'(CODE_MAX)))
    else $error("Stored code length is out of range.");

  a_pending_empty_normal: assert property (@(posedge clk) disable iff (rst)
    (mode == MODE_NORMAL) |-> (pending_len == '0))
    else $error("Pending code is held outside change mode.");

  a_stage_holds: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !s1_adv) |=> (s1_valid && $stable(s1_item)))
    else $error("Input register lost a stalled transaction.");

endmodule

`default_nettype wire
